// ===== hw/rtl/gog_pkg.sv =====
package gog_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PIX_W     = 12;
  localparam int SIZE_W    = 13;
  localparam int COORD_W   = 20;
  // normalized position is saturated to 2^19 - 1
  localparam int POS_W     = COORD_W - 1;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W + 1;
  localparam int LIN_CAP   = 7;
  localparam int RAD_CAP   = 14;
  // divider quotient: radial needs 2*FRAC_BITS + RAD_CAP bits
  localparam int QDIV_W    = 2 * FRAC_BITS + RAD_CAP;
  localparam int ROOT_W    = QDIV_W / 2;
  localparam int GP_W      = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [GP_W-1:0]   GP_ONE  = GP_W'(1) << FRAC_BITS;
  localparam logic [ROOT_W-1:0] OFS_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 3'd7;

  localparam logic       FILL_PROJ   = 1'b0;
  localparam logic       FILL_DIST   = 1'b1;
  localparam logic [1:0] REP_CLAMP   = 2'd0;
  localparam logic [1:0] REP_WRAP    = 2'd1;
  localparam logic [1:0] REP_MIRROR  = 2'd2;

  typedef struct packed {
    logic len0;
    logic sat;
    logic radial;
    logic neg;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] lin;
  } sq_side_t;

endpackage

// ===== hw/rtl/gradient_offset_generator_core.sv =====
// Channel   | Dir | Fields (lsb first)                  | Handshake
// s_axis    | in  | pixel_x[11:0], pixel_y[23:12]       | tvalid & tready
// m_axis    | out | gradient_pos[16:0], zero pad to 24  | tvalid & tready
// cfg       | in  | cfg_idx_i selects, cfg_data_i[19:0] | cfg_we_i
//
// One pixel per clock sustained while the output is not stalled; the pipe
// runs through coordinate normalization, the dot/distance products, the
// fractional divider, the square root and the output register.
// Reset clears all valid bits and loads the default gradient registers.
// A stalled output freezes every stage; s_axis_tready drops in the same cycle.
// After a write, len2 is recomputed via the registered squares, then len2_q.
module gradient_offset_generator_core import gog_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // gradient_pos[16:0], zeros[23:17]
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i
);

  logic [SIZE_W-1:0]  width_q, height_q;
  logic [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic               fill_q;
  logic [1:0]         repeat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= SIZE_W'(64);
      height_q  <= SIZE_W'(64);
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= COORD_W'(65536);
      end_y_q   <= '0;
      fill_q    <= FILL_PROJ;
      repeat_q  <= REP_CLAMP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:   width_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_HEIGHT:  height_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_START_X: start_x_q <= cfg_data_i;
        CFG_START_Y: start_y_q <= cfg_data_i;
        CFG_END_X:   end_x_q   <= cfg_data_i;
        CFG_END_Y:   end_y_q   <= cfg_data_i;
        CFG_FILL:    fill_q    <= cfg_data_i[0];
        CFG_REPEAT:  repeat_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic                     en;
  logic                     out_vld_q;
  logic [GP_W-1:0]          out_pos_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // segment vector and squared length, held beside the pipe
  logic signed [DIFF_W-1:0]   dx_w, dy_w;
  logic signed [PROD_W-2:0]   sqx_q, sqy_q;
  logic [PROD_W-1:0]          len2_q;

  assign dx_w = $signed({end_x_q[COORD_W-1], end_x_q})
              - $signed({start_x_q[COORD_W-1], start_x_q});
  assign dy_w = $signed({end_y_q[COORD_W-1], end_y_q})
              - $signed({start_y_q[COORD_W-1], start_y_q});

  always_ff @(posedge clk_i) begin
    sqx_q  <= dx_w * dx_w;
    sqy_q  <= dy_w * dy_w;
    len2_q <= PROD_W'(sqx_q) + PROD_W'(sqy_q);
  end

  logic             nd_vld;
  logic [POS_W-1:0] pos_x, pos_y;

  gog_norm_div u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .pix_x_i  (s_axis_tdata[PIX_W-1:0]),
    .pix_y_i  (s_axis_tdata[2*PIX_W-1:PIX_W]),
    .width_i  (width_q),
    .height_i (height_q),
    .valid_o  (nd_vld),
    .pos_x_o  (pos_x),
    .pos_y_o  (pos_y)
  );

  logic                     vb_q, vc_q, vd_q, ve_q;
  logic signed [DIFF_W-1:0] vx_q, vy_q;
  logic signed [PROD_W-2:0] p1_q, p2_q;
  logic signed [PROD_W-1:0] sum_q;
  logic [PROD_W-1:0]        mag_q;
  logic                     neg_q;
  logic signed [DIFF_W-1:0] b1, b2;

  assign b1 = (fill_q == FILL_DIST) ? vx_q : dx_w;
  assign b2 = (fill_q == FILL_DIST) ? vy_q : dy_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en) begin
      vb_q <= nd_vld;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q  <= $signed({2'b00, pos_x}) - $signed({start_x_q[COORD_W-1], start_x_q});
      vy_q  <= $signed({2'b00, pos_y}) - $signed({start_y_q[COORD_W-1], start_y_q});
      p1_q  <= vx_q * b1;
      p2_q  <= vy_q * b2;
      sum_q <= $signed({p1_q[PROD_W-2], p1_q}) + $signed({p2_q[PROD_W-2], p2_q});
      neg_q <= sum_q[PROD_W-1];
      mag_q <= sum_q[PROD_W-1] ? PROD_W'(-sum_q) : PROD_W'(sum_q);
    end
  end

  // divider setup: integer part must stay below 2^cap, else saturate
  logic [PROD_W-1:0] rem0;
  logic [QDIV_W-1:0] low0;
  side_t             side0;

  always_comb begin
    if (fill_q == FILL_DIST) begin
      rem0 = mag_q >> RAD_CAP;
      low0 = {mag_q[RAD_CAP-1:0], {(QDIV_W-RAD_CAP){1'b0}}};
    end else begin
      rem0 = mag_q >> LIN_CAP;
      low0 = {mag_q[LIN_CAP-1:0], {(QDIV_W-LIN_CAP){1'b0}}};
    end
    side0.len0   = (len2_q == '0);
    side0.sat    = (rem0 >= len2_q);
    side0.radial = (fill_q == FILL_DIST);
    side0.neg    = neg_q;
  end

  logic              fd_vld;
  side_t             fd_side;
  logic [QDIV_W-1:0] quot;
  sq_side_t          sq_side_in;

  gog_frac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ve_q),
    .side_i  (side0),
    .rem_i   (rem0),
    .low_i   (low0),
    .den_i   (len2_q),
    .valid_o (fd_vld),
    .side_o  (fd_side),
    .quot_o  (quot)
  );

  assign sq_side_in.side = fd_side;
  assign sq_side_in.lin  = quot[QDIV_W-1:QDIV_W-ROOT_W];

  logic              sq_vld;
  sq_side_t          sq_side;
  logic [ROOT_W-1:0] root;

  gog_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fd_vld),
    .side_i  (sq_side_in),
    .val_i   (quot),
    .valid_o (sq_vld),
    .side_o  (sq_side),
    .root_o  (root)
  );

  logic [ROOT_W-1:0] ofs_mag;
  logic [GP_W-1:0]   gp_d;
  logic [GP_W-1:0]   mir;

  always_comb begin
    if (sq_side.side.sat) begin
      ofs_mag = OFS_MAX;
    end else if (sq_side.side.radial) begin
      ofs_mag = root;
    end else begin
      ofs_mag = sq_side.lin;
    end
    mir = ofs_mag[GP_W-1:0];
    case (repeat_q)
      REP_WRAP: begin
        if (sq_side.side.neg) begin
          gp_d = {1'b0, FRAC_BITS'(FRAC_BITS'(0) - ofs_mag[FRAC_BITS-1:0])};
        end else begin
          gp_d = GP_W'(ofs_mag[FRAC_BITS-1:0]);
        end
      end
      REP_MIRROR: begin
        if (mir > GP_ONE) begin
          gp_d = GP_W'({1'b0, GP_ONE, 1'b0} - {1'b0, mir});
        end else begin
          gp_d = mir;
        end
      end
      default: begin
        if (sq_side.side.neg) begin
          gp_d = '0;
        end else if (ofs_mag > ROOT_W'(GP_ONE)) begin
          gp_d = GP_ONE;
        end else begin
          gp_d = mir;
        end
      end
    endcase
    if (sq_side.side.len0) begin
      gp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pos_q <= gp_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(24-GP_W){1'b0}}, out_pos_q};

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_pos_q <= GP_ONE)
    else $error("gradient position above 1.0");

  a_wrap_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && repeat_q == REP_WRAP |-> out_pos_q < GP_ONE)
    else $error("wrapped position reached 1.0");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vc_q) && $stable(p1_q) && $stable(mag_q))
    else $error("pipeline stage moved during stall");

endmodule

// ===== hw/rtl/gog_norm_div.sv =====
module gog_norm_div import gog_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [PIX_W-1:0]  pix_x_i,
  input  logic [PIX_W-1:0]  pix_y_i,
  input  logic [SIZE_W-1:0] width_i,
  input  logic [SIZE_W-1:0] height_i,
  output logic              valid_o,
  output logic [POS_W-1:0]  pos_x_o,
  output logic [POS_W-1:0]  pos_y_o
);

  localparam int NS    = POS_W;
  localparam int NUM_W = PIX_W + FRAC_BITS;

  logic [NS:0]        vld_q;
  logic [SIZE_W-1:0]  rem_q [2][NS+1];
  logic [SIZE_W-1:0]  rem_d [2][NS+1];
  logic [NS-1:0]      qr_q  [2][NS+1];
  logic [NS-1:0]      qr_d  [2][NS+1];
  logic [NS:0]        zero_q [2];
  logic [NS:0]        zero_d [2];
  logic [NS:0]        sat_q  [2];
  logic [NS:0]        sat_d  [2];
  logic [SIZE_W-1:0]  den    [2];
  logic [NUM_W-1:0]   num    [2];
  logic [SIZE_W:0]    trial;

  always_comb begin
    den[0] = width_i - SIZE_W'(1);
    den[1] = height_i - SIZE_W'(1);
    num[0] = {pix_x_i, {FRAC_BITS{1'b0}}};
    num[1] = {pix_y_i, {FRAC_BITS{1'b0}}};
    trial  = '0;
    for (int l = 0; l < 2; l++) begin
      rem_d[l][0]  = SIZE_W'(num[l][NUM_W-1:NS]);
      qr_d[l][0]   = num[l][NS-1:0];
      zero_d[l][0] = (l == 0) ? (width_i <= SIZE_W'(1)) : (height_i <= SIZE_W'(1));
      sat_d[l][0]  = (SIZE_W+NS)'(num[l]) >= {den[l], {NS{1'b0}}};
      // one quotient bit per stage
      for (int s = 0; s < NS; s++) begin
        trial = {rem_q[l][s], qr_q[l][s][NS-1]};
        if (trial >= {1'b0, den[l]}) begin
          rem_d[l][s+1] = SIZE_W'(trial - {1'b0, den[l]});
          qr_d[l][s+1]  = {qr_q[l][s][NS-2:0], 1'b1};
        end else begin
          rem_d[l][s+1] = SIZE_W'(trial);
          qr_d[l][s+1]  = {qr_q[l][s][NS-2:0], 1'b0};
        end
        zero_d[l][s+1] = zero_q[l][s];
        sat_d[l][s+1]  = sat_q[l][s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      qr_q   <= qr_d;
      zero_q <= zero_d;
      sat_q  <= sat_d;
    end
  end

  assign valid_o = vld_q[NS];
  assign pos_x_o = zero_q[0][NS] ? '0 : (sat_q[0][NS] ? '1 : qr_q[0][NS]);
  assign pos_y_o = zero_q[1][NS] ? '0 : (sat_q[1][NS] ? '1 : qr_q[1][NS]);

endmodule

// ===== hw/rtl/gog_frac_div.sv =====
module gog_frac_div import gog_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  side_t             side_i,
  input  logic [PROD_W-1:0] rem_i,
  input  logic [QDIV_W-1:0] low_i,
  input  logic [PROD_W-1:0] den_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [QDIV_W-1:0] quot_o
);

  localparam int NS = QDIV_W;

  logic [NS:0]       vld_q;
  side_t             side_q [NS+1];
  logic [PROD_W-1:0] rem_q  [NS+1];
  logic [PROD_W-1:0] rem_d  [NS+1];
  // low dividend bits shift out the top while quotient bits shift in
  logic [NS-1:0]     qr_q   [NS+1];
  logic [NS-1:0]     qr_d   [NS+1];
  logic [PROD_W:0]   trial;

  always_comb begin
    rem_d[0] = rem_i;
    qr_d[0]  = low_i;
    trial    = '0;
    for (int s = 0; s < NS; s++) begin
      trial = {rem_q[s], qr_q[s][NS-1]};
      if (trial >= {1'b0, den_i}) begin
        rem_d[s+1] = PROD_W'(trial - {1'b0, den_i});
        qr_d[s+1]  = {qr_q[s][NS-2:0], 1'b1};
      end else begin
        rem_d[s+1] = PROD_W'(trial);
        qr_d[s+1]  = {qr_q[s][NS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q     <= rem_d;
      qr_q      <= qr_d;
      side_q[0] <= side_i;
      for (int s = 0; s < NS; s++) begin
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign side_o  = side_q[NS];
  assign quot_o  = qr_q[NS];

endmodule

// ===== hw/rtl/gog_isqrt.sv =====
module gog_isqrt import gog_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  sq_side_t          side_i,
  input  logic [QDIV_W-1:0] val_i,
  output logic              valid_o,
  output sq_side_t          side_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int NS    = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [NS:0]        vld_q;
  sq_side_t           side_q [NS+1];
  logic [REM_W-1:0]   rem_q  [NS+1];
  logic [REM_W-1:0]   rem_d  [NS+1];
  logic [ROOT_W-1:0]  root_q [NS+1];
  logic [ROOT_W-1:0]  root_d [NS+1];
  logic [QDIV_W-1:0]  val_q  [NS+1];
  logic [QDIV_W-1:0]  val_d  [NS+1];
  logic [REM_W+1:0]   t;
  logic [REM_W+1:0]   trial;

  // two radicand bits per stage, one root bit out
  always_comb begin
    rem_d[0]  = '0;
    root_d[0] = '0;
    val_d[0]  = val_i;
    t         = '0;
    trial     = '0;
    for (int s = 0; s < NS; s++) begin
      t     = {rem_q[s], val_q[s][QDIV_W-1:QDIV_W-2]};
      trial = (REM_W+2)'({root_q[s], 2'b01});
      if (t >= trial) begin
        rem_d[s+1]  = REM_W'(t - trial);
        root_d[s+1] = {root_q[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[s+1]  = REM_W'(t);
        root_d[s+1] = {root_q[s][ROOT_W-2:0], 1'b0};
      end
      val_d[s+1] = {val_q[s][QDIV_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q     <= rem_d;
      root_q    <= root_d;
      val_q     <= val_d;
      side_q[0] <= side_i;
      for (int s = 0; s < NS; s++) begin
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign side_o  = side_q[NS];
  assign root_o  = root_q[NS];

endmodule
